FILE: design/can_multiframe_reassembler_assert.svh
// Assertion macros used by the reassembler back end (cmr_back).
// They expect clk_i and rst_ni in the scope where they are used.
`ifndef CAN_MULTIFRAME_REASSEMBLER_ASSERT_SVH
`define CAN_MULTIFRAME_REASSEMBLER_ASSERT_SVH

// Same-cycle implication.
`define CMR_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication.
`define CMR_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);

`endif

FILE: design/cmr_pkg.sv
package cmr_pkg;

  localparam logic [4:0]  TYPE_START  = 5'h1f;
  localparam logic [4:0]  TYPE_IGNORE = 5'h00;
  localparam logic [15:0] STALE_RESET = 16'd5000;

  // Field widths sized for the largest supported slot count and message size.
  localparam int SLOT_W = 4;
  localparam int LEN_W  = 7;

  typedef enum logic [1:0] {
    CMD_WRITE,
    CMD_EMIT_MEM,
    CMD_EMIT_DIRECT
  } cmd_kind_e;

  // One command from the front to the back. For CMD_WRITE, off is the byte
  // offset and cnt the byte count; for CMD_EMIT_MEM, off is the message length;
  // for CMD_EMIT_DIRECT, data and cnt carry the whole beat.
  typedef struct packed {
    cmd_kind_e          kind;
    logic [SLOT_W-1:0]  slot;
    logic [LEN_W-1:0]   off;
    logic [3:0]         cnt;
    logic [63:0]        data;
    logic [31:0]        frames;
    logic [31:0]        msgs;
    logic [31:0]        drops;
  } cmd_t;

endpackage

FILE: design/can_multiframe_reassembler.sv
// CAN multi-frame reassembler. A frame transfer happens at a clock edge with
// start high and busy low. For a start frame or a continuation, the front
// steps through an accept state, a search of the slots one by one for a
// matching, free, stale or oldest slot, a decide state and a queue push; the
// continuation that completes a message adds the emit command as a second
// push. A continuation that matches no slot ends after the decide state with
// no push, a single-frame message goes from accept straight to its emit
// push, and ignored frames leave the front idle. While the queue stays full,
// the front waits in its push state. A completed message leaves through a
// two-entry command queue to the back end, which reads the message store one
// eight-byte row per cycle and presents one beat per cycle, up to eight
// beats, a stored beat passing the read, s1 and output registers.
// The receiver cannot stall: each beat sits on the result ports for
// exactly one cycle with msg_valid_o high, and beats of a message come in
// consecutive cycles. The front only waits while the queue is full, so a new
// frame may be taken while an earlier message is still being delivered.
module can_multiframe_reassembler #(
  parameter int SLOTS     = 4,
  parameter int MSG_BYTES = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic [28:0] frame_id_i,
  input  logic [63:0] frame_data_i,
  input  logic [3:0]  frame_len_i,
  input  logic [31:0] time_ms_i,
  input  logic        cfg_we_i,
  input  logic [15:0] cfg_wdata_i,
  output logic        msg_valid_o,
  output logic [63:0] msg_bytes_o,
  output logic [3:0]  beat_count_o,
  output logic        last_beat_o,
  output logic [31:0] frames_seen_o,
  output logic [31:0] messages_done_o,
  output logic [31:0] drops_seen_o
);

  cmr_pkg::cmd_t push_cmd, head_cmd;
  logic          push, full, pop, empty;

  // The front owns slot bookkeeping, counters and the timeout register.
  cmr_front #(
    .SLOTS     (SLOTS),
    .MSG_BYTES (MSG_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .frame_id_i   (frame_id_i),
    .frame_data_i (frame_data_i),
    .frame_len_i  (frame_len_i),
    .time_ms_i    (time_ms_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .cmd_o        (push_cmd),
    .push_o       (push),
    .full_i       (full)
  );

  // Commands are kept in order, so a write always lands before a later
  // emit of the same slot reads it.
  cmr_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (full),
    .pop_i   (pop),
    .empty_o (empty),
    .head_o  (head_cmd)
  );

  // The back owns the message store and the result ports.
  cmr_back #(
    .SLOTS     (SLOTS),
    .MSG_BYTES (MSG_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .empty_i         (empty),
    .head_i          (head_cmd),
    .pop_o           (pop),
    .valid_o         (msg_valid_o),
    .msg_bytes_o     (msg_bytes_o),
    .beat_count_o    (beat_count_o),
    .last_beat_o     (last_beat_o),
    .frames_seen_o   (frames_seen_o),
    .messages_done_o (messages_done_o),
    .drops_seen_o    (drops_seen_o)
  );

endmodule

FILE: design/cmr_queue.sv
module cmr_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  cmr_pkg::cmd_t cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          empty_o,
  output cmr_pkg::cmd_t head_o
);

  cmr_pkg::cmd_t entry_q [2];
  logic          wr_ptr_q, rd_ptr_q;
  logic [1:0]    count_q;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (!push_i && pop_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

FILE: design/cmr_front.sv
module cmr_front #(
  parameter int SLOTS     = 4,
  parameter int MSG_BYTES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  output logic          busy,
  input  logic [28:0]   frame_id_i,
  input  logic [63:0]   frame_data_i,
  input  logic [3:0]    frame_len_i,
  input  logic [31:0]   time_ms_i,
  input  logic          cfg_we_i,
  input  logic [15:0]   cfg_wdata_i,
  output cmr_pkg::cmd_t cmd_o,
  output logic          push_o,
  input  logic          full_i
);

  localparam int SW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int LW = $clog2(MSG_BYTES + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_PUSH_W,
    ST_PUSH_E
  } state_e;

  state_e      state_q;
  logic [15:0] timeout_q;
  logic [31:0] frames_q, msgs_q, drops_q;

  logic          used_q  [SLOTS];
  logic [15:0]   dev_q   [SLOTS];
  logic [7:0]    seq_q   [SLOTS];
  logic [4:0]    rem_q   [SLOTS];
  logic [LW-1:0] len_q   [SLOTS];
  logic [31:0]   stamp_q [SLOTS];

  logic [15:0] key_q;
  logic [7:0]  fseq_q;
  logic [63:0] data_q;
  logic [3:0]  flen_q;
  logic [31:0] now_q;
  logic        is_start_q;
  logic [4:0]  follow_q;

  logic [SW-1:0] idx_q, midx_q, cidx_q, oidx_q;
  logic          mfound_q, cfound_q, cstale_q;
  logic [4:0]    mrem_q;
  logic [LW-1:0] mlen_q;
  logic [31:0]   ostamp_q;

  logic [SW-1:0]  w_slot_q, e_slot_q;
  logic [cmr_pkg::LEN_W-1:0] w_off_q, e_len_q;
  logic [3:0]     w_cnt_q, e_cnt_q;
  logic [63:0]    w_data_q, e_data_q;
  cmr_pkg::cmd_kind_e e_kind_q;
  logic           e_pend_q;

  logic          hit, stale, older;
  logic [31:0]   age, sdiff;
  logic [SW-1:0] start_slot;
  logic          start_drop;
  logic [LW:0]   sum_w, new_len, emit_len;
  logic [LW:0]   nclip;
  logic          len_ok;

  assign busy   = (state_q != ST_IDLE);
  assign len_ok = (frame_len_i != 4'd0) && (frame_len_i <= 4'd8);

  always_comb begin
    hit   = used_q[idx_q] && (dev_q[idx_q] == key_q) && (seq_q[idx_q] == fseq_q);
    age   = now_q - stamp_q[idx_q];
    stale = (age > {16'd0, timeout_q});
    sdiff = stamp_q[idx_q] - ostamp_q;
    older = sdiff[31];

    start_slot = mfound_q ? midx_q : (cfound_q ? cidx_q : oidx_q);
    start_drop = !mfound_q && (cstale_q || !cfound_q);

    // Append clipped to the message buffer size.
    sum_w = {1'b0, mlen_q} + (LW + 1)'(flen_q - 4'd1);
    if (sum_w > (LW + 1)'(MSG_BYTES)) begin
      nclip = (LW + 1)'(MSG_BYTES) - {1'b0, mlen_q};
    end else begin
      nclip = (LW + 1)'(flen_q - 4'd1);
    end
    new_len  = {1'b0, mlen_q} + nclip;
    emit_len = (new_len >= (LW + 1)'(2)) ? new_len - (LW + 1)'(2) : '0;
  end

  always_comb begin
    cmd_o        = '0;
    cmd_o.frames = frames_q;
    cmd_o.msgs   = msgs_q;
    cmd_o.drops  = drops_q;
    if (state_q == ST_PUSH_W) begin
      cmd_o.kind = cmr_pkg::CMD_WRITE;
      cmd_o.slot = cmr_pkg::SLOT_W'(w_slot_q);
      cmd_o.off  = w_off_q;
      cmd_o.cnt  = w_cnt_q;
      cmd_o.data = w_data_q;
    end else begin
      cmd_o.kind = e_kind_q;
      cmd_o.slot = cmr_pkg::SLOT_W'(e_slot_q);
      cmd_o.off  = e_len_q;
      cmd_o.cnt  = e_cnt_q;
      cmd_o.data = e_data_q;
    end
    push_o = ((state_q == ST_PUSH_W) || (state_q == ST_PUSH_E)) && !full_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      timeout_q <= cmr_pkg::STALE_RESET;
      frames_q  <= '0;
      msgs_q    <= '0;
      drops_q   <= '0;
      e_pend_q  <= 1'b0;
      e_kind_q  <= cmr_pkg::CMD_EMIT_MEM;
      for (int i = 0; i < SLOTS; i++) begin
        used_q[i]  <= 1'b0;
        dev_q[i]   <= '0;
        seq_q[i]   <= '0;
        rem_q[i]   <= '0;
        len_q[i]   <= '0;
        stamp_q[i] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (start && len_ok) begin
            frames_q   <= frames_q + 32'd1;
            key_q      <= frame_id_i[15:0];
            data_q     <= frame_data_i;
            flen_q     <= frame_len_i;
            now_q      <= time_ms_i;
            follow_q   <= frame_data_i[7:3];
            idx_q      <= '0;
            mfound_q   <= 1'b0;
            cfound_q   <= 1'b0;
            cstale_q   <= 1'b0;
            if (frame_id_i[28:24] == cmr_pkg::TYPE_START) begin
              is_start_q <= 1'b1;
              fseq_q     <= frame_data_i[15:8];
              if (frame_len_i >= 4'd2) begin
                if (frame_data_i[7:3] == 5'd0) begin
                  // Single frame: the payload goes straight out.
                  msgs_q   <= msgs_q + 32'd1;
                  e_kind_q <= cmr_pkg::CMD_EMIT_DIRECT;
                  e_data_q <= frame_data_i >> 8;
                  e_cnt_q  <= frame_len_i - 4'd1;
                  e_slot_q <= '0;
                  e_len_q  <= '0;
                  state_q  <= ST_PUSH_E;
                end else begin
                  state_q <= ST_SCAN;
                end
              end
            end else if (frame_id_i[28:24] != cmr_pkg::TYPE_IGNORE) begin
              is_start_q <= 1'b0;
              fseq_q     <= frame_data_i[7:0];
              state_q    <= ST_SCAN;
            end
          end
        end
        ST_SCAN: begin
          if (!mfound_q && hit) begin
            mfound_q <= 1'b1;
            midx_q   <= idx_q;
            mrem_q   <= rem_q[idx_q];
            mlen_q   <= len_q[idx_q];
          end
          if (idx_q == '0) begin
            oidx_q   <= '0;
            ostamp_q <= stamp_q[idx_q];
          end
          if (!cfound_q) begin
            if (!used_q[idx_q]) begin
              cfound_q <= 1'b1;
              cidx_q   <= idx_q;
            end else if (stale) begin
              cfound_q <= 1'b1;
              cstale_q <= 1'b1;
              cidx_q   <= idx_q;
            end else if ((idx_q != '0) && older) begin
              oidx_q   <= idx_q;
              ostamp_q <= stamp_q[idx_q];
            end
          end
          if (idx_q == SW'(SLOTS - 1)) begin
            state_q <= ST_DECIDE;
          end else begin
            idx_q <= idx_q + SW'(1);
          end
        end
        ST_DECIDE: begin
          if (is_start_q) begin
            if (start_drop) begin
              drops_q <= drops_q + 32'd1;
            end
            used_q[start_slot]  <= 1'b1;
            dev_q[start_slot]   <= key_q;
            seq_q[start_slot]   <= fseq_q;
            rem_q[start_slot]   <= follow_q - 5'd1;
            stamp_q[start_slot] <= now_q;
            len_q[start_slot]   <= LW'(flen_q - 4'd2);
            w_slot_q <= start_slot;
            w_off_q  <= '0;
            w_cnt_q  <= flen_q - 4'd2;
            w_data_q <= data_q >> 16;
            e_pend_q <= 1'b0;
            state_q  <= ST_PUSH_W;
          end else if (!mfound_q) begin
            state_q <= ST_IDLE;
          end else begin
            len_q[midx_q] <= LW'(new_len);
            w_slot_q <= midx_q;
            w_off_q  <= cmr_pkg::LEN_W'(mlen_q);
            w_cnt_q  <= 4'(nclip);
            w_data_q <= data_q >> 8;
            if (mrem_q <= 5'd1) begin
              used_q[midx_q] <= 1'b0;
              rem_q[midx_q]  <= '0;
              msgs_q         <= msgs_q + 32'd1;
              e_pend_q       <= 1'b1;
              e_kind_q       <= cmr_pkg::CMD_EMIT_MEM;
              e_slot_q       <= midx_q;
              e_len_q        <= cmr_pkg::LEN_W'(emit_len);
              e_cnt_q        <= '0;
              e_data_q       <= '0;
            end else begin
              rem_q[midx_q] <= mrem_q - 5'd1;
              e_pend_q      <= 1'b0;
            end
            state_q <= ST_PUSH_W;
          end
        end
        ST_PUSH_W: begin
          if (!full_i) begin
            state_q <= e_pend_q ? ST_PUSH_E : ST_IDLE;
          end
        end
        ST_PUSH_E: begin
          if (!full_i) begin
            state_q <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

FILE: design/cmr_back.sv
`include "can_multiframe_reassembler_assert.svh"

module cmr_back #(
  parameter int SLOTS     = 4,
  parameter int MSG_BYTES = 64
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          empty_i,
  input  cmr_pkg::cmd_t head_i,
  output logic          pop_o,
  output logic          valid_o,
  output logic [63:0]   msg_bytes_o,
  output logic [3:0]    beat_count_o,
  output logic          last_beat_o,
  output logic [31:0]   frames_seen_o,
  output logic [31:0]   messages_done_o,
  output logic [31:0]   drops_seen_o
);

  localparam int ROWS  = (MSG_BYTES + 7) / 8;
  localparam int DEPTH = SLOTS * ROWS;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;

  typedef enum logic {
    B_IDLE,
    B_EMIT
  } state_e;

  state_e   state_q;
  logic [cmr_pkg::SLOT_W-1:0] slot_q;
  logic [RW-1:0]  row_q;
  logic [cmr_pkg::LEN_W-1:0] rem_q;
  logic [31:0]    frames_q, msgs_q, drops_q;

  logic           s1_valid_q, s1_direct_q, s1_last_q;
  logic [63:0]    s1_data_q;
  logic [3:0]     s1_cnt_q;
  logic [31:0]    s1_frames_q, s1_msgs_q, s1_drops_q;

  logic [7:0]     rd_q [8];
  logic [AW-1:0]  rd_addr;
  logic           do_write;
  logic [3:0]     beat_cnt;
  logic           beat_last;
  logic [63:0]    raw, masked;

  assign pop_o    = (state_q == B_IDLE) && !empty_i;
  assign do_write = pop_o && (head_i.kind == cmr_pkg::CMD_WRITE);
  assign rd_addr  = AW'(int'(slot_q) * ROWS + int'(row_q));
  assign beat_cnt  = (rem_q > cmr_pkg::LEN_W'(8)) ? 4'd8 : 4'(rem_q);
  assign beat_last = (rem_q <= cmr_pkg::LEN_W'(8));

  // Byte lane l holds message bytes whose offset is l modulo eight, so an
  // unaligned write of up to eight bytes touches each lane once.
  for (genvar l = 0; l < 8; l++) begin : g_lane
    logic [7:0]    mem [DEPTH];
    logic [2:0]    k;
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wbyte;

    always_comb begin
      k     = 3'(l) - head_i.off[2:0];
      we    = do_write && ({1'b0, k} < head_i.cnt);
      waddr = AW'(int'(head_i.slot) * ROWS + ((int'(head_i.off) + int'(k)) >> 3));
      wbyte = 8'(head_i.data >> (8 * k));
    end

    always_ff @(posedge clk_i) begin
      if (we) begin
        mem[waddr] <= wbyte;
      end
      rd_q[l] <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= B_IDLE;
      s1_valid_q <= 1'b0;
      valid_o    <= 1'b0;
    end else begin
      s1_valid_q <= 1'b0;
      unique case (state_q)
        B_IDLE: begin
          if (pop_o) begin
            unique case (head_i.kind)
              cmr_pkg::CMD_EMIT_MEM: begin
                slot_q   <= head_i.slot;
                row_q    <= '0;
                rem_q    <= head_i.off;
                frames_q <= head_i.frames;
                msgs_q   <= head_i.msgs;
                drops_q  <= head_i.drops;
                state_q  <= B_EMIT;
              end
              cmr_pkg::CMD_EMIT_DIRECT: begin
                s1_valid_q  <= 1'b1;
                s1_direct_q <= 1'b1;
                s1_data_q   <= head_i.data;
                s1_cnt_q    <= head_i.cnt;
                s1_last_q   <= 1'b1;
                s1_frames_q <= head_i.frames;
                s1_msgs_q   <= head_i.msgs;
                s1_drops_q  <= head_i.drops;
              end
              default: ;
            endcase
          end
        end
        B_EMIT: begin
          s1_valid_q  <= 1'b1;
          s1_direct_q <= 1'b0;
          s1_cnt_q    <= beat_cnt;
          s1_last_q   <= beat_last;
          s1_frames_q <= frames_q;
          s1_msgs_q   <= msgs_q;
          s1_drops_q  <= drops_q;
          rem_q       <= rem_q - cmr_pkg::LEN_W'(beat_cnt);
          row_q       <= row_q + RW'(1);
          if (beat_last) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
      valid_o <= s1_valid_q;
    end
  end

  always_comb begin
    for (int b = 0; b < 8; b++) begin
      raw[8*b +: 8] = rd_q[b];
    end
    if (s1_direct_q) begin
      raw = s1_data_q;
    end
    for (int b = 0; b < 8; b++) begin
      masked[8*b +: 8] = (4'(b) < s1_cnt_q) ? raw[8*b +: 8] : 8'd0;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_bytes_o     <= masked;
    beat_count_o    <= s1_cnt_q;
    last_beat_o     <= s1_last_q;
    frames_seen_o   <= s1_frames_q;
    messages_done_o <= s1_msgs_q;
    drops_seen_o    <= s1_drops_q;
  end

  `CMR_ASSERT_IMPLIES(a_cnt_range, valid_o, beat_count_o <= 4'd8, "beat count above eight")
  `CMR_ASSERT_IMPLIES(a_partial_last, valid_o && beat_count_o != 4'd8, last_beat_o, "partial beat not last")
  `CMR_ASSERT_NEXT(a_beats_back_to_back, valid_o && !last_beat_o, valid_o, "gap inside a message")

endmodule

FILE: sim/can_multiframe_reassembler_tb.sv
module can_multiframe_reassembler_tb;

  localparam int NUM_SLOTS = 4;
  localparam int MAX_MSG   = 64;
  localparam int CYCLE_LIMIT = 1500000;
  // Allows for the back end draining the command queue: two queued messages
  // of eight beats each plus pipeline depth.
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [63:0] bytes;
    logic [3:0]  cnt;
    logic        last;
    logic [31:0] frames;
    logic [31:0] msgs;
    logic [31:0] drops;
  } beat_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [28:0] frame_id_i = '0;
  logic [63:0] frame_data_i = '0;
  logic [3:0]  frame_len_i = '0;
  logic [31:0] time_ms_i = '0;
  logic        cfg_we_i = 1'b0;
  logic [15:0] cfg_wdata_i = '0;
  logic        msg_valid_o;
  logic [63:0] msg_bytes_o;
  logic [3:0]  beat_count_o;
  logic        last_beat_o;
  logic [31:0] frames_seen_o;
  logic [31:0] messages_done_o;
  logic [31:0] drops_seen_o;

  can_multiframe_reassembler #(.SLOTS(NUM_SLOTS), .MSG_BYTES(MAX_MSG)) uut (
    .clk_i(clk_i), .rst_ni(rst_ni), .start(start), .busy(busy),
    .frame_id_i(frame_id_i), .frame_data_i(frame_data_i),
    .frame_len_i(frame_len_i), .time_ms_i(time_ms_i),
    .cfg_we_i(cfg_we_i), .cfg_wdata_i(cfg_wdata_i),
    .msg_valid_o(msg_valid_o), .msg_bytes_o(msg_bytes_o),
    .beat_count_o(beat_count_o), .last_beat_o(last_beat_o),
    .frames_seen_o(frames_seen_o), .messages_done_o(messages_done_o),
    .drops_seen_o(drops_seen_o)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the block state, kept in step with every accepted frame.
  logic [15:0] stale_ms;
  logic        sh_used   [NUM_SLOTS];
  logic [15:0] sh_device [NUM_SLOTS];
  logic [7:0]  sh_seq    [NUM_SLOTS];
  logic [5:0]  sh_remain [NUM_SLOTS];
  logic [7:0]  sh_len    [NUM_SLOTS];
  logic [31:0] sh_stamp  [NUM_SLOTS];
  logic [7:0]  sh_buf    [NUM_SLOTS][MAX_MSG];
  logic [31:0] frame_cnt, msg_cnt, drop_cnt;

  beat_t pending_beats[$];
  bit    failed = 1'b0;
  int    cycle_count = 0;
  int    idle_pct = 0;
  int    delivered = 0;
  logic [31:0] now_ms = 32'd0;

  function automatic void reset_shadow();
    stale_ms = cmr_pkg::STALE_RESET;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      sh_used[i] = 1'b0; sh_device[i] = '0; sh_seq[i] = '0;
      sh_remain[i] = '0; sh_len[i] = '0; sh_stamp[i] = '0;
      for (int k = 0; k < MAX_MSG; k++) sh_buf[i][k] = '0;
    end
    frame_cnt = '0; msg_cnt = '0; drop_cnt = '0;
  endfunction

  // Splits a finished message into eight-byte beats; an empty
  // message still yields one beat with no valid bytes.
  function automatic void queue_message(logic [7:0] src[MAX_MSG], int n);
    int nbeats;
    int cnt;
    beat_t b;
    nbeats = (n == 0) ? 1 : (n + 7) / 8;
    if (nbeats > 8) nbeats = 8;
    for (int bi = 0; bi < nbeats; bi++) begin
      cnt = n - bi * 8;
      if (cnt < 0) cnt = 0;
      if (cnt > 8) cnt = 8;
      b = '0;
      for (int k = 0; k < cnt; k++) b.bytes[8*k +: 8] = src[bi*8 + k];
      b.cnt = cnt[3:0];
      b.last = (bi + 1 == nbeats);
      b.frames = frame_cnt; b.msgs = msg_cnt; b.drops = drop_cnt;
      pending_beats.push_back(b);
    end
  endfunction

  function automatic int find_slot(logic [15:0] key, logic [7:0] seq);
    for (int i = 0; i < NUM_SLOTS; i++)
      if (sh_used[i] && sh_device[i] == key && sh_seq[i] == seq) return i;
    return -1;
  endfunction

  // The first slot that is free or stale, else the oldest by signed
  // stamp difference with ties to the lower index.
  function automatic int pick_victim(logic [31:0] now);
    int oldest;
    logic [31:0] age, diff;
    oldest = 0;
    for (int i = 0; i < NUM_SLOTS; i++) begin
      if (!sh_used[i]) return i;
      age = now - sh_stamp[i];
      if (age > {16'd0, stale_ms}) begin
        sh_used[i] = 1'b0; drop_cnt++;
        return i;
      end
      diff = sh_stamp[i] - sh_stamp[oldest];
      if (diff[31]) oldest = i;
    end
    drop_cnt++;
    sh_used[oldest] = 1'b0;
    return oldest;
  endfunction

  function automatic void predict_frame(logic [28:0] id, logic [63:0] data,
                                        logic [3:0] len, logic [31:0] now);
    logic [7:0] d[8];
    logic [7:0] tmp[MAX_MSG];
    logic [4:0] ftype;
    logic [15:0] key;
    int s, n, have, follow, total;
    if (len == 0 || len > 8) return;
    for (int i = 0; i < 8; i++) d[i] = data[8*i +: 8];
    frame_cnt++;
    ftype = id[28:24];
    key = id[15:0];
    if (ftype == cmr_pkg::TYPE_START) begin
      if (len < 2) return;
      follow = int'(d[0][7:3]);
      if (follow == 0) begin
        msg_cnt++;
        for (int k = 0; k < MAX_MSG; k++) tmp[k] = (k < 7) ? d[k+1] : 8'h00;
        queue_message(tmp, int'(len) - 1);
        return;
      end
      s = find_slot(key, d[1]);
      if (s < 0) s = pick_victim(now);
      sh_used[s] = 1'b1; sh_device[s] = key; sh_seq[s] = d[1];
      sh_remain[s] = 6'(follow - 1); sh_stamp[s] = now;
      n = int'(len) - 2;
      for (int i = 0; i < n; i++) sh_buf[s][i] = d[2+i];
      sh_len[s] = 8'(n);
      return;
    end
    if (ftype == cmr_pkg::TYPE_IGNORE) return;
    s = find_slot(key, d[0]);
    if (s < 0) return;
    have = int'(sh_len[s]);
    n = int'(len) - 1;
    if (have + n > MAX_MSG) n = MAX_MSG - have;
    for (int i = 0; i < n; i++) sh_buf[s][have+i] = d[1+i];
    sh_len[s] = 8'(have + n);
    if (sh_remain[s] <= 1) begin
      total = int'(sh_len[s]);
      sh_used[s] = 1'b0; sh_remain[s] = '0; msg_cnt++;
      for (int k = 0; k < MAX_MSG; k++) tmp[k] = sh_buf[s][k];
      queue_message(tmp, (total >= 2) ? total - 2 : 0);
      return;
    end
    sh_remain[s]--;
  endfunction

  // Drives one frame at the falling edge and holds it until the block takes
  // it. Start stays high after the transfer until the next falling edge,
  // where the next frame or an idle cycle replaces it.
  task automatic send_frame(logic [28:0] id, logic [63:0] data, logic [3:0] len,
                            logic [31:0] now);
    while (idle_pct > 0 && $urandom_range(99, 0) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk_i);
    end
    start <= 1'b1;
    frame_id_i <= id; frame_data_i <= data; frame_len_i <= len; time_ms_i <= now;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    predict_frame(id, data, len, now);
    @(negedge clk_i);
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    while (pending_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_timeout(logic [15:0] value);
    wait_drained();
    cfg_we_i <= 1'b1; cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    stale_ms = value;
  endtask

  function automatic logic [28:0] make_id(logic [4:0] ftype, logic [15:0] key);
    logic [28:0] id;
    id = 29'($urandom); // random middle bits 23:16
    id[28:24] = ftype; id[15:0] = key;
    return id;
  endfunction

  // Builds a start frame and its continuations with random bytes; frame count
  // bits 7:3 of byte 0 are the follow count.
  task automatic send_message(logic [15:0] key, logic [7:0] seq, int follow,
                              int step_ms);
    logic [63:0] data;
    logic [4:0]  ctype;
    data = {$urandom, $urandom};
    data[7:0] = {follow[4:0], data[2:0]};
    data[15:8] = seq;
    send_frame(make_id(cmr_pkg::TYPE_START, key), data, 4'($urandom_range(8, 2)), now_ms);
    for (int f = 0; f < follow; f++) begin
      now_ms += step_ms;
      data = {$urandom, $urandom};
      data[7:0] = seq;
      ctype = 5'($urandom_range(30, 1));
      send_frame(make_id(ctype, key), data, 4'($urandom_range(8, 1)), now_ms);
    end
  endtask

  always @(posedge clk_i) begin
    beat_t want;
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout", $time);
      $display("can_multiframe_reassembler verification failed");
      $finish;
    end
    if (rst_ni && msg_valid_o) begin
      if (pending_beats.size() == 0) begin
        $display("%0t: unexpected beat %h", $time, msg_bytes_o);
        failed = 1'b1;
      end else begin
        want = pending_beats.pop_front();
        delivered++;
        if ({msg_bytes_o, beat_count_o, last_beat_o, frames_seen_o,
             messages_done_o, drops_seen_o} !== want) begin
          $display("%0t: beat mismatch expected bytes=%h cnt=%0d last=%0b fr=%0d msg=%0d dr=%0d",
                   $time, want.bytes, want.cnt, want.last, want.frames, want.msgs,
                   want.drops);
          $display("%0t:   actual bytes=%h cnt=%0d last=%0b fr=%0d msg=%0d dr=%0d",
                   $time, msg_bytes_o, beat_count_o, last_beat_o, frames_seen_o,
                   messages_done_o, drops_seen_o);
          failed = 1'b1;
        end
      end
    end
  end

  // Directed: extremes of lengths, single frames, short starts, ignored types,
  // overflow clipping, unmatched continuations and short messages.
  task automatic test_directed();
    send_frame(make_id(cmr_pkg::TYPE_START, 16'h1234), 64'hFFFF_FFFF_FFFF_FF07, 4'd8,
               now_ms);
    send_frame(make_id(cmr_pkg::TYPE_START, 16'h0000), 64'h0, 4'd0, now_ms);
    send_frame(make_id(cmr_pkg::TYPE_START, 16'h0000), 64'hAA, 4'd15, now_ms);
    send_frame(make_id(cmr_pkg::TYPE_START, 16'hFFFF), 64'h08, 4'd1, now_ms);
    send_frame(make_id(cmr_pkg::TYPE_START, 16'h0001), 64'h5500, 4'd2, now_ms);
    send_frame(make_id(cmr_pkg::TYPE_IGNORE, 16'h0001), 64'hFFFF_FFFF_FFFF_FFFF, 4'd8,
               now_ms);
    send_frame(make_id(5'h01, 16'h7777), 64'h0123_4567_89AB_CD42, 4'd8, now_ms);
    send_message(16'hFFFF, 8'hFF, 31, 1);
    send_message(16'h0000, 8'h00, 1, 1);
    // Message with one data byte overall: emitted as an empty beat.
    send_frame(make_id(cmr_pkg::TYPE_START, 16'h0042), 64'h0000_0000_0000_3308, 4'd2,
               now_ms);
    send_frame(make_id(5'h1e, 16'h0042), 64'h0000_0000_0000_AB33, 4'd2, now_ms);
    send_message(16'h5A5A, 8'h81, 2, 3);
  endtask

  // Five interleaved messages on four slots force eviction of the oldest.
  task automatic test_eviction();
    for (int k = 0; k < 5; k++) begin
      now_ms += 2;
      send_frame(make_id(cmr_pkg::TYPE_START, 16'(16'h0100 + k)),
                 {48'h0, 8'(k), 8'h10}, 4'd8, now_ms);
    end
    for (int k = 0; k < 5; k++)
      send_frame(make_id(5'h02, 16'(16'h0100 + k)),
                 {32'($urandom), 24'($urandom), 8'(k)}, 4'd8, now_ms);
    for (int k = 0; k < 5; k++)
      send_frame(make_id(5'h02, 16'(16'h0100 + k)),
                 {32'($urandom), 24'($urandom), 8'(k)}, 4'd8, now_ms);
  endtask

  task automatic test_random(int count, int pct);
    int kind;
    logic [63:0] data;
    idle_pct = pct;
    for (int i = 0; i < count; i++) begin
      now_ms += $urandom_range(3000, 0);
      if ($urandom_range(7, 0) == 0) now_ms = {$urandom};
      kind = $urandom_range(9, 0);
      if (kind < 7) begin
        send_message($urandom_range(3, 0) == 0 ? 16'($urandom) : 16'($urandom_range(5, 0)),
                     8'($urandom_range(3, 0)), $urandom_range(5, 0) == 0 ?
                     $urandom_range(31, 1) : $urandom_range(4, 1), $urandom_range(400, 0));
        i += 2;
      end else begin
        data = {$urandom, $urandom};
        send_frame(make_id(5'($urandom), 16'($urandom_range(5, 0))), data,
                   4'($urandom), now_ms);
      end
    end
    idle_pct = 0;
  endtask

  initial begin
    reset_shadow();
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_eviction();
    write_timeout(16'd0);
    test_random(42, 0);
    write_timeout(16'hFFFF);
    test_random(47, 84);
    write_timeout(16'd700);
    test_random(52, 27);
    write_timeout(16'd2500);
    test_random(31, 0);
    wait_drained();
    if (!failed && pending_beats.size() == 0) begin
      $display("can_multiframe_reassembler verification clean");
    end else begin
      $display("can_multiframe_reassembler verification failed");
    end
    $finish;
  end

endmodule

FILE: sim.f
+incdir+design
design/cmr_pkg.sv
design/cmr_queue.sv
design/cmr_front.sv
design/cmr_back.sv
design/can_multiframe_reassembler.sv
sim/can_multiframe_reassembler_tb.sv
